// File: sv/ffha_pkg.sv
// Package for the first-fit heap allocator: status codes, function codes and defaults.
// No dependencies.
`timescale 1ns / 1ps
package ffha_pkg;
  localparam int MaxSegmentsDef = 64;
  localparam int HeaderBytesDef = 32;
  localparam int HeapBytesDef = 65536;
  localparam int MinRemainder = 4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;
endpackage

// File: sv/ffha_if.sv
// Valid/ready channel interfaces for the allocator request and response.
// Depends on nothing.
`timescale 1ns / 1ps
interface ffha_req_if;
  logic valid;
  logic ready;
  logic func;
  logic [15:0] elem_count;
  logic [15:0] elem_bytes;
  logic [15:0] free_addr;
  modport source (output valid, func, elem_count, elem_bytes, free_addr, input ready);
  modport sink (input valid, func, elem_count, elem_bytes, free_addr, output ready);
endinterface

interface ffha_rsp_if;
  logic valid;
  logic ready;
  logic [15:0] addr;
  logic [1:0] status;
  modport source (output valid, addr, status, input ready);
  modport sink (input valid, addr, status, output ready);
endinterface

// File: sv/ffha_seg_mem.sv
// Segment table memory: start, payload bytes and free flag per entry.
// One write port, one registered read port. Uses ffha_pkg.
`timescale 1ns / 1ps
module ffha_seg_mem
  import ffha_pkg::*;
#(
  parameter int MAX_SEGMENTS = MaxSegmentsDef,
  localparam int AW = $clog2(MAX_SEGMENTS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [33:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [33:0]   rdata
);
  logic [33:0] mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/first_fit_heap_allocator.sv
// First-fit heap allocator over an address-ordered segment table in one memory.
// A request runs through the table search, then shifts the later entries when an
// allocation splits a free segment or a free merges neighbours, then gives its
// response beat.
// One request at a time: the next is taken the cycle after the response beat leaves.
// Reset (rst, synchronous) empties the table and sets heap_limit to 65536.
`timescale 1ns / 1ps
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int MAX_SEGMENTS = MaxSegmentsDef,
  parameter int HEADER_BYTES = HeaderBytesDef,
  parameter int HEAP_BYTES   = HeapBytesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  ffha_req_if.sink    req,
  ffha_rsp_if.source  rsp
);
  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_SEGMENTS);
  localparam logic [17:0] Hdr = 18'(HEADER_BYTES);
  localparam logic [17:0] HeapCap = (HEAP_BYTES > 65536) ? 18'd65536 : 18'(HEAP_BYTES);

  // Sequencer codes. Each table entry packs {free, bytes[16:0], start[15:0]}.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_SRCH   = 4'd3;  // read issued, data next cycle
  localparam logic [3:0] S_EVAL   = 4'd4;
  localparam logic [3:0] S_SHR    = 4'd5;  // shift right: read k-1
  localparam logic [3:0] S_SHRW   = 4'd6;  // wait for the read data
  localparam logic [3:0] S_SHL    = 4'd7;  // shift left: read the entry that moves to k
  localparam logic [3:0] S_SHLW   = 4'd8;  // write k
  localparam logic [3:0] S_FNEXT  = 4'd9;  // free: read next neighbour
  localparam logic [3:0] S_FPREV  = 4'd10; // free: evaluate next, read previous
  localparam logic [3:0] S_FDEC   = 4'd11; // free: decide merges
  localparam logic [3:0] S_RESP   = 4'd12;
  localparam logic [3:0] S_SHRD   = 4'd13; // shift right: write k

  logic [3:0]    state;
  logic [16:0]   heap_limit;
  logic [CW-1:0] seg_count;
  logic [17:0]   heap_top;

  // Request latch.
  logic          op;
  logic [15:0]   cnt_q, bytes_q, fa_q;
  logic [31:0]   total;
  logic [17:0]   need;

  // Search and shift pointers.
  logic [CW-1:0] idx;
  logic [CW-1:0] k;
  logic [CW-1:0] stop;

  // Held entries and the pending write once the shift is done.
  logic [33:0]   hit_e, nxt_e;
  logic          fix_we;
  logic [AW-1:0] fix_addr;
  logic [33:0]   fix_data;
  logic [AW-1:0] fix2_addr;
  logic [33:0]   fix2_data;

  logic [15:0]   out_addr;
  logic [1:0]    out_status;

  // Memory port.
  logic          m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [33:0]   m_wdata, m_rdata;

  ffha_seg_mem #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_mem (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );

  // The effective bound is the least of heap_limit and the heap size.
  logic [17:0] lim;
  assign lim = ({1'b0, heap_limit} < HeapCap) ? {1'b0, heap_limit} : HeapCap;

  // Product rounded up to 4; only meaningful once the product is within the bound.
  logic [17:0] need_c;
  assign need_c = ((total[17:0] - 18'd1) & ~18'd3) + 18'd4;

  logic        r_free;
  logic [16:0] r_bytes;
  logic [15:0] r_start;
  assign {r_free, r_bytes, r_start} = m_rdata;

  logic [17:0] rest;
  assign rest = {1'b0, r_bytes} - need;

  assign req.ready = (state == S_IDLE) && !rsp.valid;
  assign rsp.addr = out_addr;
  assign rsp.status = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_we <= 1'b0;
      state <= S_IDLE;
      heap_limit <= 17'd65536;
      seg_count <= '0;
      heap_top <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_limit <= cfg_wdata;
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          m_we <= 1'b0;
          if (req.valid && req.ready) begin
            op <= req.func;
            cnt_q <= req.elem_count;
            bytes_q <= req.elem_bytes;
            fa_q <= req.free_addr;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          m_we <= 1'b0;
          total <= {16'd0, cnt_q} * {16'd0, bytes_q};
          state <= S_CHECK;
        end
        S_CHECK: begin
          // A product above the bound fails before its rounding is looked at.
          m_we <= 1'b0;
          idx <= '0;
          out_addr <= '0;
          fix_we <= 1'b0;
          m_raddr <= '0;
          if (op == FUNC_ALLOC) begin
            if (total == 32'd0) begin
              out_status <= ST_ZERO;
              state <= S_RESP;
            end else if (total > {14'd0, lim} || need_c > lim) begin
              out_status <= ST_NOSPACE;
              state <= S_RESP;
            end else begin
              need <= need_c;
              state <= (seg_count == '0) ? S_EVAL : S_SRCH;
            end
          end else if (fa_q == 16'd0) begin
            out_status <= ST_OK;
            state <= S_RESP;
          end else begin
            state <= (seg_count == '0) ? S_EVAL : S_SRCH;
          end
        end
        S_SRCH: begin
          m_we <= 1'b0;
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (idx == seg_count) begin
            // Search ran off the end.
            if (op == FUNC_FREE) begin
              m_we <= 1'b0;
              out_status <= ST_BADFREE;
              state <= S_RESP;
            end else if (seg_count >= MaxCnt ||
                         heap_top + Hdr + need > lim) begin
              m_we <= 1'b0;
              out_status <= ST_NOSPACE;
              state <= S_RESP;
            end else begin
              m_we <= 1'b1;
              m_waddr <= idx[AW-1:0];
              m_wdata <= {1'b0, need[16:0], heap_top[15:0]};
              seg_count <= seg_count + 1'b1;
              heap_top <= heap_top + Hdr + need;
              out_addr <= heap_top[15:0] + Hdr[15:0];
              out_status <= ST_OK;
              state <= S_RESP;
            end
          end else if (op == FUNC_ALLOC && r_free && {1'b0, r_bytes} >= need) begin
            out_addr <= r_start + Hdr[15:0];
            out_status <= ST_OK;
            if (rest >= Hdr + 18'(MinRemainder) && seg_count < MaxCnt) begin
              // Split: open slot idx+1, then write both halves.
              m_we <= 1'b0;
              fix_we <= 1'b1;
              fix_addr <= idx[AW-1:0];
              fix_data <= {1'b0, need[16:0], r_start};
              fix2_addr <= AW'(idx + 1'b1);
              fix2_data <= {1'b1, 17'(rest - Hdr), r_start + Hdr[15:0] + need[15:0]};
              k <= seg_count;
              stop <= idx + 1'b1;
              seg_count <= seg_count + 1'b1;
              state <= S_SHR;
            end else begin
              m_we <= 1'b1;
              m_waddr <= idx[AW-1:0];
              m_wdata <= {1'b0, r_bytes, r_start};
              state <= S_RESP;
            end
          end else if (op == FUNC_FREE && !r_free &&
                       {2'b0, r_start} + Hdr == {2'b0, fa_q}) begin
            m_we <= 1'b0;
            hit_e <= {1'b1, r_bytes, r_start};
            out_status <= ST_OK;
            m_raddr <= AW'(idx + 1'b1);
            state <= S_FNEXT;
          end else begin
            m_we <= 1'b0;
            idx <= idx + 1'b1;
            m_raddr <= AW'(idx + 1'b1);
            state <= (idx + 1'b1 == seg_count) ? S_EVAL : S_SRCH;
          end
        end
        S_FNEXT: begin
          m_we <= 1'b0;
          m_raddr <= AW'(idx - 1'b1);
          state <= S_FPREV;
        end
        S_FPREV: begin
          m_we <= 1'b0;
          if (idx + 1'b1 < seg_count && r_free) begin
            nxt_e <= m_rdata;
          end else begin
            nxt_e <= '0;
          end
          state <= S_FDEC;
        end
        S_FDEC: begin : fdec
          logic          nf, pf;
          logic [33:0]   cur;
          logic [CW-1:0] h, cnt;
          nf = nxt_e[33];
          pf = (idx != '0) && r_free;
          cur = hit_e;
          cnt = seg_count;
          h = idx;
          if (nf) begin
            cur[32:16] = cur[32:16] + nxt_e[32:16] + Hdr[16:0];
            cnt = cnt - 1'b1;
          end
          if (pf) begin
            cur = {1'b1, r_bytes + cur[32:16] + Hdr[16:0], r_start};
            cnt = cnt - 1'b1;
            h = idx - 1'b1;
          end
          m_we <= 1'b0;
          fix_addr <= h[AW-1:0];
          fix_data <= cur;
          if (h + 1'b1 == cnt) begin
            // Trailing free segment goes back to the heap top.
            heap_top <= {2'b0, cur[15:0]};
            seg_count <= cnt - 1'b1;
            state <= S_RESP;
          end else begin
            fix_we <= 1'b1;
            seg_count <= cnt;
            // Close up removed slots: entries from idx+1+nf move down by (nf+pf).
            stop <= cnt;
            idx <= h + 1'b1 + CW'(nf) + CW'(pf);
            if (nf || pf) begin
              k <= h + 1'b1;
              m_raddr <= AW'(h + 1'b1 + CW'(nf) + CW'(pf));
              state <= S_SHL;
            end else begin
              k <= cnt;
              state <= S_SHLW;
            end
          end
        end
        S_SHR: begin
          if (k == stop) begin
            m_we <= 1'b1;
            if (fix_we) begin
              m_waddr <= fix_addr;
              m_wdata <= fix_data;
              fix_we <= 1'b0;
            end else begin
              m_waddr <= fix2_addr;
              m_wdata <= fix2_data;
              state <= S_RESP;
            end
          end else begin
            m_we <= 1'b0;
            m_raddr <= AW'(k - 1'b1);
            state <= S_SHRW;
          end
        end
        S_SHRW: begin
          // The read addressed in S_SHR is in the memory now; its data is used in S_SHRD.
          m_we <= 1'b0;
          state <= S_SHRD;
        end
        S_SHRD: begin
          m_we <= 1'b1;
          m_waddr <= k[AW-1:0];
          m_wdata <= m_rdata;
          k <= k - 1'b1;
          state <= S_SHR;
        end
        S_SHL: begin
          m_we <= 1'b0;
          state <= S_SHLW;
        end
        S_SHLW: begin
          if (k >= stop) begin
            m_we <= fix_we;
            m_waddr <= fix_addr;
            m_wdata <= fix_data;
            state <= S_RESP;
          end else begin
            m_we <= 1'b1;
            m_waddr <= k[AW-1:0];
            m_wdata <= m_rdata;
            k <= k + 1'b1;
            idx <= idx + 1'b1;
            m_raddr <= AW'(idx + 1'b1);
            state <= S_SHL;
          end
        end
        S_RESP: begin
          m_we <= 1'b0;
          rsp.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          m_we <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A response beat never carries an address with a failure status.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.addr == 16'd0)
    else $error("failed request returned an address");
  // The table never holds more than its capacity.
  a_cnt: assert property (@(posedge clk) disable iff (rst) seg_count <= MaxCnt)
    else $error("segment count overflow");
  // The heap top never passes the hard heap size.
  a_top: assert property (@(posedge clk) disable iff (rst) heap_top <= 18'd65536)
    else $error("heap top beyond heap");
`endif
endmodule
